// File: rtl/dwt_pkg.sv
// ----------------------------------------------------------------------------
// dwt_pkg: shared types and constants for the dual wheel tachometer
// Field widths, fixed-point constants, register indexes and the lane
// command/status structs.
// ----------------------------------------------------------------------------
package dwt_pkg;

    localparam int CountBits = 16;
    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    localparam int TimeBits  = 32;
    localparam int SlotBits  = 8;
    localparam int DiaBits   = 16;
    localparam int ScaleBits = 16;
    localparam int DivBits   = TimeBits + SlotBits;
    localparam int RpmBits   = 15;
    localparam int QBits     = RpmBits + 1;
    localparam int StepBits  = $clog2(QBits);
    localparam int NumBits   = CountBits + ScaleBits;
    localparam int DshBits   = DivBits + RpmBits;

    localparam int PiBits      = 18;
    localparam int P1Bits      = DiaBits + RpmBits;
    localparam int P2Bits      = P1Bits + PiBits;
    localparam int SpeedShift  = 18;
    localparam int XBits       = P2Bits - SpeedShift;
    localparam int SpeedLimit  = 491520;
    localparam int XNarrow     = $clog2(SpeedLimit);
    localparam int RecipBits   = 20;
    localparam int RecipShift  = 23;
    localparam int ProdBits    = XNarrow + RecipBits;

    localparam logic [ScaleBits-1:0] RpmScale   = 16'd60000;
    localparam logic [RpmBits-1:0]   OutMax     = 15'h7fff;
    localparam logic [PiBits-1:0]    PiQ16      = 18'd205887;
    localparam logic [RecipBits-1:0] RecipFifteen = 20'd559240;
    localparam logic [XNarrow-1:0]   Fifteen    = XNarrow'(15);

    localparam int CfgIdxBits  = 1;
    localparam int CfgDataBits = 16;
    localparam logic [CfgIdxBits-1:0] RegWheelDia = 1'b0;
    localparam logic [CfgIdxBits-1:0] RegSlots    = 1'b1;
    localparam logic [DiaBits-1:0]    DiaReset    = 16'd65;
    localparam logic [SlotBits-1:0]   SlotsReset  = 8'd20;

    typedef enum logic [1:0] {
        T_IDLE,
        T_DIV,
        T_WAIT
    } t_top_state;

    typedef enum logic [3:0] {
        L_IDLE,
        L_NUM,
        L_LOAD,
        L_DIV,
        L_RPM,
        L_MUL,
        L_PI,
        L_RECIP,
        L_FIX,
        L_DONE
    } t_lane_state;

    typedef struct packed {
        logic               take;
        logic               pulse;
        logic               close;
        logic               ack;
        logic [DiaBits-1:0] dia;
        logic [DivBits-1:0] div;
    } t_lane_cmd;

    typedef struct packed {
        logic               done;
        logic [RpmBits-1:0] rpm;
        logic [RpmBits-1:0] speed;
    } t_lane_stat;

endpackage

// File: rtl/dwt_lane.sv
// ----------------------------------------------------------------------------
// dwt_lane: one wheel channel
// Saturating pulse counter, iterative rpm divider and fixed-point speed
// conversion for a single wheel.
// ----------------------------------------------------------------------------
module dwt_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dwt_pkg::t_lane_cmd i_cmd,
    output dwt_pkg::t_lane_stat o_stat
);

    dwt_pkg::t_lane_state r_state, n_state;

    logic [dwt_pkg::CountBits-1:0] r_count;
    logic [dwt_pkg::CountBits-1:0] r_hold;
    logic [dwt_pkg::NumBits-1:0]   r_num;
    logic [dwt_pkg::DshBits-1:0]   r_dsh;
    logic [dwt_pkg::QBits-1:0]     r_q;
    logic [dwt_pkg::StepBits-1:0]  r_step;
    logic [dwt_pkg::RpmBits-1:0]   r_rpm;
    logic [dwt_pkg::P1Bits-1:0]    r_p1;
    logic [dwt_pkg::P2Bits-1:0]    r_p2;
    logic [dwt_pkg::XNarrow-1:0]   r_x;
    logic [dwt_pkg::RpmBits-1:0]   r_qe;
    logic                          r_ssat;
    logic [dwt_pkg::RpmBits-1:0]   r_speed;

    logic [dwt_pkg::CountBits-1:0] w_bump;
    logic                          w_ge;
    logic [dwt_pkg::XBits-1:0]     w_x;
    logic [dwt_pkg::ProdBits-1:0]  w_prod;
    logic [dwt_pkg::XNarrow-1:0]   w_rem;

    assign w_bump = (r_count == dwt_pkg::CountMax) ? r_count
                                                   : r_count + dwt_pkg::CountBits'(1);
    assign w_ge   = {(dwt_pkg::DshBits - dwt_pkg::NumBits)'(0), r_num} >= r_dsh;
    assign w_x    = r_p2[dwt_pkg::P2Bits-1:dwt_pkg::SpeedShift];
    assign w_prod = dwt_pkg::ProdBits'(w_x[dwt_pkg::XNarrow-1:0])
                  * dwt_pkg::ProdBits'(dwt_pkg::RecipFifteen);
    assign w_rem  = r_x - dwt_pkg::XNarrow'(r_qe) * dwt_pkg::Fifteen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwt_pkg::L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dwt_pkg::L_IDLE:  if (i_cmd.take && i_cmd.close) n_state = dwt_pkg::L_NUM;
            dwt_pkg::L_NUM:   n_state = dwt_pkg::L_LOAD;
            dwt_pkg::L_LOAD:  n_state = dwt_pkg::L_DIV;
            dwt_pkg::L_DIV:   if (r_step == '0) n_state = dwt_pkg::L_RPM;
            dwt_pkg::L_RPM:   n_state = dwt_pkg::L_MUL;
            dwt_pkg::L_MUL:   n_state = dwt_pkg::L_PI;
            dwt_pkg::L_PI:    n_state = dwt_pkg::L_RECIP;
            dwt_pkg::L_RECIP: n_state = dwt_pkg::L_FIX;
            dwt_pkg::L_FIX:   n_state = dwt_pkg::L_DONE;
            dwt_pkg::L_DONE:  if (i_cmd.ack) n_state = dwt_pkg::L_IDLE;
            default:          n_state = dwt_pkg::L_IDLE;
        endcase
    end

    // count pulses; a closing transfer counts its own pulse first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == dwt_pkg::L_IDLE && i_cmd.take) begin
            if (i_cmd.close) begin
                r_count <= '0;
            end else if (i_cmd.pulse) begin
                r_count <= w_bump;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dwt_pkg::L_IDLE: begin
                r_hold <= i_cmd.pulse ? w_bump : r_count;
            end
            dwt_pkg::L_NUM: begin
                r_num <= dwt_pkg::NumBits'(r_hold) * dwt_pkg::NumBits'(dwt_pkg::RpmScale);
            end
            dwt_pkg::L_LOAD: begin
                r_dsh  <= {i_cmd.div, dwt_pkg::RpmBits'(0)};
                r_q    <= '0;
                r_step <= dwt_pkg::StepBits'(dwt_pkg::QBits - 1);
            end
            dwt_pkg::L_DIV: begin
                if (w_ge) begin
                    r_num <= r_num - r_dsh[dwt_pkg::NumBits-1:0];
                end
                r_q    <= {r_q[dwt_pkg::QBits-2:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step - dwt_pkg::StepBits'(1);
            end
            dwt_pkg::L_RPM: begin
                r_rpm <= r_q[dwt_pkg::QBits-1] ? dwt_pkg::OutMax
                                               : r_q[dwt_pkg::RpmBits-1:0];
            end
            dwt_pkg::L_MUL: begin
                r_p1 <= dwt_pkg::P1Bits'(i_cmd.dia) * dwt_pkg::P1Bits'(r_rpm);
            end
            dwt_pkg::L_PI: begin
                r_p2 <= dwt_pkg::P2Bits'(r_p1) * dwt_pkg::P2Bits'(dwt_pkg::PiQ16);
            end
            dwt_pkg::L_RECIP: begin
                r_ssat <= w_x >= dwt_pkg::XBits'(dwt_pkg::SpeedLimit);
                r_x    <= w_x[dwt_pkg::XNarrow-1:0];
                r_qe   <= w_prod[dwt_pkg::RecipShift +: dwt_pkg::RpmBits];
            end
            dwt_pkg::L_FIX: begin
                if (r_ssat) begin
                    r_speed <= dwt_pkg::OutMax;
                end else if (w_rem >= dwt_pkg::Fifteen) begin
                    r_speed <= r_qe + dwt_pkg::RpmBits'(1);
                end else begin
                    r_speed <= r_qe;
                end
            end
            default: begin
                r_hold <= r_hold;
            end
        endcase
    end

    assign o_stat.done  = (r_state == dwt_pkg::L_DONE);
    assign o_stat.rpm   = r_rpm;
    assign o_stat.speed = r_speed;

endmodule

// File: rtl/dual_wheel_tachometer_unit.sv
// ----------------------------------------------------------------------------
// dual_wheel_tachometer_unit: two-wheel pulse-count tachometer
// Input transfers carry pulse flags and a millisecond time; a transfer with
// s_axis_tlast set closes the window and yields one rpm/speed result.
// Input tdata:  [0] left_pulse, [1] right_pulse, [33:2] now_ms, [39:34] zero.
// Input tlast:  window_close.
// Output tdata: [14:0] l_rpm, [29:15] r_rpm, [44:30] l_speed,
//               [59:45] r_speed, [91:60] update_time_ms, [95:92] zero.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx
//         (0 wheel diameter in mm, 1 slots per revolution).
// A transfer without tlast leaves s_axis_tready high. A closing transfer
// keeps s_axis_tready low while the window is evaluated: the divisor product,
// a 16-step restoring divider in each wheel lane, then three multiply stages
// and a reciprocal correction for speed. The result then enters the output
// register; the next transfer is accepted while it waits there. If the
// receiver still holds an older result, the lanes wait until it is taken.
// Reset clears counters, the last close time (to 0), the output valid and
// restores the register defaults.
// ----------------------------------------------------------------------------
module dual_wheel_tachometer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [39:0]                      s_axis_tdata,  // left_pulse, right_pulse, now_ms
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [95:0]                      m_axis_tdata,  // l_rpm, r_rpm, l_spd, r_spd, time
    input  logic                             i_cfg_we,
    input  logic [dwt_pkg::CfgIdxBits-1:0]   i_cfg_idx,
    input  logic [dwt_pkg::CfgDataBits-1:0]  i_cfg_data
);

    dwt_pkg::t_top_state r_state, n_state;

    logic [dwt_pkg::DiaBits-1:0]  r_dia;
    logic [dwt_pkg::SlotBits-1:0] r_slots;
    logic [dwt_pkg::TimeBits-1:0] r_last;
    logic [dwt_pkg::TimeBits-1:0] r_now;
    logic [dwt_pkg::TimeBits-1:0] r_elapsed;
    logic [dwt_pkg::DivBits-1:0]  r_div;
    logic                         r_out_valid;
    logic [91:0]                  r_out_data;

    logic                         w_take;
    logic                         w_load;
    logic [dwt_pkg::TimeBits-1:0] w_now;
    logic [dwt_pkg::TimeBits-1:0] w_elapsed;

    dwt_pkg::t_lane_cmd  w_cmd_l, w_cmd_r;
    dwt_pkg::t_lane_stat w_stat_l, w_stat_r;

    assign w_take    = s_axis_tvalid && s_axis_tready;
    assign w_now     = s_axis_tdata[33:2];
    assign w_elapsed = w_now - r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwt_pkg::T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            dwt_pkg::T_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tlast) n_state = dwt_pkg::T_DIV;
            end
            dwt_pkg::T_DIV: begin
                n_state = dwt_pkg::T_WAIT;
            end
            dwt_pkg::T_WAIT: begin
                if (w_stat_l.done && w_stat_r.done && (!r_out_valid || m_axis_tready)) begin
                    w_load  = 1'b1;
                    n_state = dwt_pkg::T_IDLE;
                end
            end
            default: begin
                n_state = dwt_pkg::T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dia   <= dwt_pkg::DiaReset;
            r_slots <= dwt_pkg::SlotsReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dwt_pkg::RegWheelDia: r_dia   <= i_cfg_data[dwt_pkg::DiaBits-1:0];
                dwt_pkg::RegSlots:    r_slots <= i_cfg_data[dwt_pkg::SlotBits-1:0];
                default:              r_dia   <= r_dia;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (w_take && s_axis_tlast) begin
            r_last <= w_now;
        end
    end

    // elapsed forced to 1 on a repeated time; divisor forced to 1 with no slots
    always_ff @(posedge i_clk) begin
        if (w_take && s_axis_tlast) begin
            r_now     <= w_now;
            r_elapsed <= (w_elapsed == '0) ? dwt_pkg::TimeBits'(1) : w_elapsed;
        end
        if (r_state == dwt_pkg::T_DIV) begin
            r_div <= (r_slots == '0) ? dwt_pkg::DivBits'(1)
                   : dwt_pkg::DivBits'(r_elapsed) * dwt_pkg::DivBits'(r_slots);
        end
    end

    always_comb begin
        w_cmd_l.take  = w_take;
        w_cmd_l.pulse = s_axis_tdata[0];
        w_cmd_l.close = s_axis_tlast;
        w_cmd_l.ack   = w_load;
        w_cmd_l.dia   = r_dia;
        w_cmd_l.div   = r_div;
        w_cmd_r       = w_cmd_l;
        w_cmd_r.pulse = s_axis_tdata[1];
    end

    dwt_lane u_lane_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_l),
        .o_stat  (w_stat_l)
    );

    dwt_lane u_lane_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_r),
        .o_stat  (w_stat_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {r_now, w_stat_r.speed, w_stat_l.speed,
                           w_stat_r.rpm, w_stat_l.rpm};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_data};

endmodule

// File: rtl/dwt_checker.sv
// ----------------------------------------------------------------------------
// dwt_checker: port-level checks for the dual wheel tachometer
// Watches reset, output hold, and the busy window after a closing transfer.
// ----------------------------------------------------------------------------
module dwt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [95:0]                     m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during window evaluation");

    a_plain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("non-closing transfer stalled input");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a window evaluation");

endmodule

bind dual_wheel_tachometer_unit dwt_checker u_dwt_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dual_wheel_tachometer_unit
// Drives pulse and window-close transfers with random gaps on both streams,
// predicts each rpm/speed result in a scoreboard with its own copy of the
// counters, last close time and registers, and compares every output
// transfer field by field. Covers register extremes, output saturation,
// same-millisecond and wrapped closes, zero slots and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import dwt_pkg::*;

    localparam logic [63:0] SpeedDiv = 64'd3932160;
    localparam int SettleCycles = 40;
    localparam int HoldCycles = 400;

    typedef struct packed {
        logic [RpmBits-1:0] l_rpm;
        logic [RpmBits-1:0] r_rpm;
        logic [RpmBits-1:0] l_spd;
        logic [RpmBits-1:0] r_spd;
        logic [31:0]        stamp;
    } t_speed_reading;

    class wheel_speed_board;
        logic [DiaBits-1:0]   dia;
        logic [SlotBits-1:0]  slots;
        logic [CountBits-1:0] left_cnt;
        logic [CountBits-1:0] right_cnt;
        logic [31:0]          last_ms;
        t_speed_reading       readings_due[$];
        int                   errors;
        int                   readings;

        function new();
            dia = DiaReset;
            slots = SlotsReset;
            left_cnt = '0;
            right_cnt = '0;
            last_ms = '0;
            errors = 0;
            readings = 0;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
            if (idx == RegWheelDia) begin
                dia = val;
            end else if (idx == RegSlots) begin
                slots = val[SlotBits-1:0];
            end
        endfunction

        function logic [RpmBits-1:0] rpm_of(logic [CountBits-1:0] cnt, logic [63:0] divisor);
            logic [63:0] q;
            q = (64'(cnt) * 64'(RpmScale)) / divisor;
            return (q > 64'(OutMax)) ? OutMax : q[RpmBits-1:0];
        endfunction

        function logic [RpmBits-1:0] speed_of(logic [RpmBits-1:0] rpm);
            logic [63:0] q;
            q = (64'(dia) * 64'(rpm) * 64'(PiQ16)) / SpeedDiv;
            return (q > 64'(OutMax)) ? OutMax : q[RpmBits-1:0];
        endfunction

        function void take_item(logic lp, logic rp, logic close, logic [31:0] stamp);
            logic [31:0]    span;
            logic [63:0]    divisor;
            t_speed_reading r;
            if (lp && left_cnt != CountMax) left_cnt = left_cnt + 1'b1;
            if (rp && right_cnt != CountMax) right_cnt = right_cnt + 1'b1;
            if (!close) return;
            span = stamp - last_ms;
            if (span == 32'd0) span = 32'd1;
            last_ms = stamp;
            divisor = 64'(span) * 64'(slots);
            if (divisor == 64'd0) divisor = 64'd1;
            r.l_rpm = rpm_of(left_cnt, divisor);
            r.r_rpm = rpm_of(right_cnt, divisor);
            r.l_spd = speed_of(r.l_rpm);
            r.r_spd = speed_of(r.r_rpm);
            r.stamp = stamp;
            readings_due.push_back(r);
            left_cnt = '0;
            right_cnt = '0;
        endfunction

        function void cmp(string what, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
            end
        endfunction

        function void check_reading(logic [95:0] data);
            t_speed_reading e;
            readings++;
            if (readings_due.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual %h", $time, data);
                return;
            end
            e = readings_due.pop_front();
            cmp("l_rpm", 32'(e.l_rpm), 32'(data[14:0]));
            cmp("r_rpm", 32'(e.r_rpm), 32'(data[29:15]));
            cmp("l_speed", 32'(e.l_spd), 32'(data[44:30]));
            cmp("r_speed", 32'(e.r_spd), 32'(data[59:45]));
            cmp("update_time_ms", e.stamp, data[91:60]);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [39:0]            s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [95:0]            m_axis_tdata;
    logic                   i_cfg_we;
    logic [CfgIdxBits-1:0]  i_cfg_idx;
    logic [CfgDataBits-1:0] i_cfg_data;

    wheel_speed_board board;
    bit               idle_on;
    bit               hold_req;
    logic [31:0]      ms_now;
    int               items_sent;
    int               settings;

    dual_wheel_tachometer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random gaps, one long hold-off on request
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            board.check_reading(m_axis_tdata);
        end
    end

    task automatic send_item(logic lp, logic rp, logic close, logic [31:0] stamp);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, stamp, rp, lp};
        s_axis_tlast  <= close;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_item(lp, rp, close, stamp);
        items_sent++;
        if (close) ms_now = stamp;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [DiaBits-1:0] dia, logic [SlotBits-1:0] slots);
        logic [CfgDataBits-1:0] slot_word;
        slot_word = {8'($urandom), slots};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= RegWheelDia;
        i_cfg_data <= dia;
        @(posedge i_clk);
        i_cfg_idx  <= RegSlots;
        i_cfg_data <= slot_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_reg(RegWheelDia, dia);
        board.set_reg(RegSlots, slot_word);
        settings++;
    endtask

    task automatic directed_items();
        send_item(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(1'b1, 1'b1, 1'b0, 32'h0000_0000);
        send_item(1'b0, 1'b1, 1'b1, 32'd1000);
        send_item(1'b1, 1'b1, 1'b1, 32'd1000);
        repeat (11) send_item(1'b1, 1'b1, 1'b0, $urandom);
        send_item(1'b0, 1'b0, 1'b1, 32'd1001);
        send_item(1'b1, 1'b0, 1'b1, 32'hFFFF_FFF0);
        send_item(1'b0, 1'b1, 1'b1, 32'h0000_0010);
        send_item(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_item(1'b1, 1'b0, 1'b0, 32'h5555_5555);
        send_item(1'b0, 1'b1, 1'b1, 32'hAAAA_AAAA);
        settle();
        write_cfg(16'd0, 8'd0);
        send_item(1'b1, 1'b1, 1'b1, ms_now + 32'd5000);
        settle();
        write_cfg(16'hFFFF, 8'hFF);
        send_item(1'b1, 1'b0, 1'b1, ms_now + 32'd1);
        send_item(1'b1, 1'b1, 1'b1, ms_now + 32'd700);
    endtask

    task automatic random_windows(int n);
        int          budget;
        int          k;
        int          lp_pct;
        int          rp_pct;
        logic [31:0] step;
        budget = n;
        while (budget > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom), 1'($urandom), 1'($urandom), $urandom);
                budget--;
            end else begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
                lp_pct = $urandom_range(0, 100);
                rp_pct = $urandom_range(0, 100);
                for (int i = 0; i < k && budget > 1; i++) begin
                    send_item($urandom_range(1, 100) <= lp_pct, $urandom_range(1, 100) <= rp_pct,
                              1'b0, $urandom);
                    budget--;
                end
                case ($urandom_range(0, 9))
                    0:       step = 32'd0;
                    1:       step = $urandom;
                    2, 3:    step = $urandom_range(1, 10);
                    default: step = $urandom_range(1, 5000);
                endcase
                send_item(1'($urandom), 1'($urandom), 1'b1, ms_now + step);
                budget--;
            end
        end
    endtask

    initial begin
        board = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        idle_on = 1'b0;
        hold_req = 1'b0;
        ms_now = '0;
        items_sent = 0;
        settings = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        settle();
        write_cfg(16'd65, 8'd20);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       write_cfg(16'd0, 8'd0);
                1:       write_cfg(16'hFFFF, 8'hFF);
                2:       write_cfg(16'hFFFF, 8'd1);
                3:       write_cfg(16'd1, 8'hFF);
                default: write_cfg(16'($urandom), 8'($urandom_range(1, 40)));
            endcase
            idle_on = (p != 4);
            if (p == 2) hold_req = 1'b1;
            if (p == 3) begin
                random_windows(85);
                s_axis_tvalid <= 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
                @(posedge i_clk);
                random_windows(85);
            end else begin
                random_windows(170);
            end
            settle();
        end

        $display("run: %0d input transfers, %0d results checked, %0d register settings",
                 items_sent, board.readings, settings);
        $display("incl. rpm and speed saturation, same-ms and wrapped closes, zero slots, long hold-off");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
